// ===== rtl/rsg_pkg.sv =====
// ============================================================================
// rsg_pkg
// Types and constants shared by the range speed governor modules.
// ============================================================================
package rsg_pkg;

    // payload widths
    localparam int RANGE_W    = 16;
    localparam int DIST_W     = 24;
    localparam int ALPHA_W    = 9;
    localparam int FACTOR_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // fixed-point ones
    localparam logic [FACTOR_W-1:0] Q15_ONE   = 16'h8000;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DISTANCE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_ALPHA = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_ALPHA   = 8'd3;

    // register reset values
    localparam logic [RANGE_W-1:0] STOP_RESET   = 16'd250;
    localparam logic [RANGE_W-1:0] SLOW_RESET   = 16'd800;
    localparam logic [ALPHA_W-1:0] DALPHA_RESET = 9'd77;
    localparam logic [ALPHA_W-1:0] FALPHA_RESET = 9'd26;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DSUM,
        ST_RAMP,
        ST_DIV,
        ST_FMUL,
        ST_FSUM
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic dist_seed;
        logic dist_mul;
        logic dist_upd;
        logic ramp_eval;
        logic div_start;
        logic raw_load;
        logic fac_mul;
        logic fac_upd;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sample_ready;
        logic dist_zero;
        logic need_div;
        logic div_done;
        logic out_full;
    } status_t;

    // weights above one saturate to one
    function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

// ===== rtl/rsg_if.sv =====
// ============================================================================
// rsg_if
// Valid/ready channels of the range speed governor: sample, result, config.
// ============================================================================
interface rsg_in_if;
    import rsg_pkg::*;

    logic               valid;
    logic               ready;
    logic               sample_ready;
    logic [RANGE_W-1:0] range_mm;

    modport source (output valid, output sample_ready, output range_mm, input ready);
    modport sink   (input valid, input sample_ready, input range_mm, output ready);
endinterface

interface rsg_out_if;
    import rsg_pkg::*;

    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] speed_factor;

    modport source (output valid, output speed_factor, input ready);
    modport sink   (input valid, input speed_factor, output ready);
endinterface

interface rsg_cfg_if;
    import rsg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rsg_divider.sv =====
// ============================================================================
// rsg_divider
// Restoring divider for the speed ramp, one quotient bit per cycle.
// ============================================================================
module rsg_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [rsg_pkg::DIST_W-1:0]   num,
    input  logic [rsg_pkg::DIST_W-1:0]   den,
    output logic                    done,
    output logic [rsg_pkg::FACTOR_W-1:0] quo
);
    import rsg_pkg::*;

    localparam int CNT_W = $clog2(FACTOR_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIST_W:0]  rem_reg, rem_next;
    logic [DIST_W-1:0] den_reg, den_next;
    logic [FACTOR_W-1:0] quo_reg, quo_next;
    logic [DIST_W:0]  sub;

    // one compare and subtract per step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        sub       = rem_reg - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= {1'b0, den_reg})
            begin
                rem_next = {sub[DIST_W-1:0], 1'b0};
                quo_next = {quo_reg[FACTOR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIST_W-1:0], 1'b0};
                quo_next = {quo_reg[FACTOR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(FACTOR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/rsg_datapath.sv =====
// ============================================================================
// rsg_datapath
// Config registers, distance and factor filters, ramp and result register.
// ============================================================================
module rsg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsg_pkg::cmd_t               cmd,
    output rsg_pkg::status_t            status,
    input  logic                        smp_ready,
    input  logic [rsg_pkg::RANGE_W-1:0] smp_range,
    rsg_cfg_if.sink                     cfg,
    rsg_out_if.source                   result
);
    import rsg_pkg::*;

    logic [RANGE_W-1:0]  stop_reg, slow_reg;
    logic [ALPHA_W-1:0]  dalpha_reg, falpha_reg;
    logic                rdy_reg;
    logic [RANGE_W-1:0]  x_reg;
    logic [DIST_W-1:0]   d_reg;
    logic [FACTOR_W-1:0] f_reg;
    logic [DIST_W:0]     pnew_reg;
    logic [DIST_W+ALPHA_W-1:0] pold_reg;
    logic [FACTOR_W-1:0] raw_reg;
    logic [DIST_W-1:0]   fp1_reg, fp2_reg;
    logic                out_valid_reg;
    logic [FACTOR_W-1:0] out_data_reg;

    logic [ALPHA_W-1:0]  da, fa;
    logic [DIST_W:0]     d_sum;
    logic [DIST_W-1:0]   s_val, w_val, ramp_num, ramp_den;
    logic                above, below, degen;
    logic [DIST_W:0]     f_sum;
    logic [FACTOR_W:0]   f_shift;
    logic [FACTOR_W-1:0] f_new;
    logic                div_done;
    logic [FACTOR_W-1:0] div_quo;
    logic                out_take;

    assign cfg.ready = 1'b1;

    // saturated weights
    assign da = sat_alpha(dalpha_reg);
    assign fa = sat_alpha(falpha_reg);

    // distance filter sum
    assign d_sum = pnew_reg + pold_reg[DIST_W+ALPHA_W-1:8];

    // ramp compare
    assign s_val    = {stop_reg, 8'h00};
    assign w_val    = {slow_reg, 8'h00};
    assign above    = d_reg > w_val;
    assign below    = d_reg < s_val;
    assign degen    = w_val <= s_val;
    assign ramp_num = d_reg - s_val;
    assign ramp_den = w_val - s_val;

    // factor filter sum with clamp
    assign f_sum   = (DIST_W+1)'(fp1_reg) + (DIST_W+1)'(fp2_reg);
    assign f_shift = f_sum[DIST_W:8];
    assign f_new   = (f_shift > {1'b0, Q15_ONE}) ? Q15_ONE : f_shift[FACTOR_W-1:0];

    rsg_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (ramp_num),
        .den   (ramp_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_take = result.valid && result.ready;

    // status to controller
    always_comb
    begin
        status.sample_ready = rdy_reg;
        status.dist_zero    = (d_reg == '0);
        status.need_div     = !above && !below && !degen;
        status.div_done     = div_done;
        status.out_full     = out_valid_reg && !result.ready;
    end

    // config registers and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg      <= STOP_RESET;
            slow_reg      <= SLOW_RESET;
            dalpha_reg    <= DALPHA_RESET;
            falpha_reg    <= FALPHA_RESET;
            d_reg         <= '0;
            f_reg         <= Q15_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_STOP_DISTANCE:  stop_reg   <= cfg.data;
                    REG_SLOW_DISTANCE:  slow_reg   <= cfg.data;
                    REG_DISTANCE_ALPHA: dalpha_reg <= cfg.data[ALPHA_W-1:0];
                    REG_FACTOR_ALPHA:   falpha_reg <= cfg.data[ALPHA_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.dist_seed)
                d_reg <= {x_reg, 8'h00};
            else if (cmd.dist_upd)
                d_reg <= d_sum[DIST_W-1:0];
            if (cmd.fac_upd)
                f_reg <= f_new;
            if (cmd.fac_upd)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and product registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rdy_reg <= smp_ready;
            x_reg   <= smp_range;
        end
        if (cmd.dist_mul)
        begin
            pnew_reg <= (DIST_W+1)'(da) * (DIST_W+1)'(x_reg);
            pold_reg <= (DIST_W+ALPHA_W)'(ALPHA_ONE - da) * (DIST_W+ALPHA_W)'(d_reg);
        end
        if (cmd.ramp_eval)
            raw_reg <= above ? Q15_ONE : '0;
        else if (cmd.raw_load)
            raw_reg <= div_quo;
        if (cmd.fac_mul)
        begin
            fp1_reg <= DIST_W'(fa) * DIST_W'(raw_reg);
            fp2_reg <= DIST_W'(ALPHA_ONE - fa) * DIST_W'(f_reg);
        end
        if (cmd.fac_upd)
            out_data_reg <= f_new;
    end

    assign result.valid        = out_valid_reg;
    assign result.speed_factor = out_data_reg;

    // smoothed factor never leaves the unit range
    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        f_reg <= Q15_ONE)
        else $error("smoothed factor above one");

    // ramp quotient is bounded by one
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> div_quo <= Q15_ONE)
        else $error("ramp quotient above one");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fac_upd |-> !(out_valid_reg && !result.ready))
        else $error("result register overwritten while held");

    // divider is only started on a ramp that needs it
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (cmd.ramp_eval && !above && !below && !degen))
        else $error("divider started outside the ramp band");

endmodule

// ===== rtl/rsg_ctrl.sv =====
// ============================================================================
// rsg_ctrl
// Sequencer that steps one sample through the filters, ramp and output.
// ============================================================================
module rsg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             smp_valid,
    output logic             smp_accept_ok,
    input  rsg_pkg::status_t status,
    output rsg_pkg::cmd_t    cmd
);
    import rsg_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (smp_valid)
                    state_next = ST_DIST;
            ST_DIST:
                if (status.sample_ready && !status.dist_zero)
                    state_next = ST_DSUM;
                else
                    state_next = ST_RAMP;
            ST_DSUM:
                state_next = ST_RAMP;
            ST_RAMP:
                state_next = status.need_div ? ST_DIV : ST_FMUL;
            ST_DIV:
                if (status.div_done)
                    state_next = ST_FMUL;
            ST_FMUL:
                state_next = ST_FSUM;
            ST_FSUM:
                if (!status.out_full)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        smp_accept_ok = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                smp_accept_ok = 1'b1;
                cmd.load_in   = smp_valid;
            end
            ST_DIST:
            begin
                cmd.dist_seed = status.sample_ready && status.dist_zero;
                cmd.dist_mul  = status.sample_ready && !status.dist_zero;
            end
            ST_DSUM:
                cmd.dist_upd = 1'b1;
            ST_RAMP:
            begin
                cmd.ramp_eval = 1'b1;
                cmd.div_start = status.need_div;
            end
            ST_DIV:
                cmd.raw_load = status.div_done;
            ST_FMUL:
                cmd.fac_mul = 1'b1;
            ST_FSUM:
                cmd.fac_upd = !status.out_full;
            default:
                cmd = '0;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/range_speed_governor.sv =====
// ============================================================================
// range_speed_governor
// Range-driven speed limiter: distance filter, linear ramp, factor filter.
// ============================================================================
// Each accepted sample tick yields one Q1.15 speed factor. A tick runs from
// acceptance through the distance, ramp, factor multiply and factor sum
// steps back to idle. A distance update step is added when a distance
// multiply-accumulate is needed, and a division step when the filtered
// distance lies inside the ramp band, where a 16-step restoring divider
// (one quotient bit per cycle) forms the raw factor. The result sits in an
// output register, so a new tick is taken while the previous factor waits
// for its transfer. That tick then holds in its last step until the register
// is free. Config writes are always taken and should be made while idle.
// ============================================================================
module range_speed_governor (
    input  logic     clk,
    input  logic     rst_n,
    rsg_in_if.sink   sample,
    rsg_out_if.source result,
    rsg_cfg_if.sink  cfg
);
    import rsg_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    accept_ok;

    assign sample.ready = accept_ok;

    rsg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .smp_valid     (sample.valid),
        .smp_accept_ok (accept_ok),
        .status        (status),
        .cmd           (cmd)
    );

    rsg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .smp_ready (sample.sample_ready),
        .smp_range (sample.range_mm),
        .cfg       (cfg),
        .result    (result)
    );

endmodule

// ===== tb/sv/range_speed_governor_tb.sv =====
// ============================================================================
// range_speed_governor_tb
// Self-checking testbench for the range speed governor.
// ============================================================================
// Sample ticks go in over the sample channel, and every tick transfer is run
// through a local model of both filters and the distance ramp. The result is
// queued, and each speed factor transfer is compared with the oldest queued
// value. A short table of directed ticks and register writes comes first. It
// covers reset, the extremes, saturated weights, equal thresholds and the
// reseed of a zero distance. Random phases follow, each under its own
// register setting, with random gaps on the sample side and random stalls on
// the result side. The last phases run at full rate.
// ============================================================================
module range_speed_governor_tb;
    import rsg_pkg::*;

    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PHASES  = 12;
    localparam int TICKS_PER_PHASE = 153;
    localparam longint RUN_LIMIT  = 64'd6_000_000;

    // one row of the directed table: a register write or a tick
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  sr;
        logic [RANGE_W-1:0]    rng;
        logic                  has_want;
        logic [FACTOR_W-1:0]   want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    rsg_in_if  sample_ch ();
    rsg_out_if result_ch ();
    rsg_cfg_if cfg_ch ();

    range_speed_governor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // model of the register file
    logic [RANGE_W-1:0] stop_cfg   = STOP_RESET;
    logic [RANGE_W-1:0] slow_cfg   = SLOW_RESET;
    logic [ALPHA_W-1:0] dalpha_cfg = DALPHA_RESET;
    logic [ALPHA_W-1:0] falpha_cfg = FALPHA_RESET;

    // model of the filter state
    logic [DIST_W-1:0]   dist_q   = '0;
    logic [FACTOR_W-1:0] factor_q = Q15_ONE;

    logic [FACTOR_W-1:0] pending_factors [$];
    plan_row_t           plan [$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int fail_count = 0;
    int samples_sent = 0;
    int factors_checked = 0;
    int settings_applied = 0;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // distance filter, ramp and factor filter for one tick
    function automatic logic [FACTOR_W-1:0] predict_speed_factor(input logic sr,
                                                                 input logic [RANGE_W-1:0] rng);
        logic [63:0] wgt;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] raw;
        begin
            if (sr)
            begin
                if (dist_q == '0)
                begin
                    dist_q = {rng, 8'h00};
                end
                else
                begin
                    wgt = (dalpha_cfg > ALPHA_ONE) ? 64'd256 : 64'(dalpha_cfg);
                    acc = wgt * 64'({rng, 8'h00}) + (64'd256 - wgt) * 64'(dist_q);
                    dist_q = acc[31:8];
                end
            end
            s = 64'({stop_cfg, 8'h00});
            w = 64'({slow_cfg, 8'h00});
            if (64'(dist_q) > w)
                raw = 64'(Q15_ONE);
            else if (64'(dist_q) < s)
                raw = 64'd0;
            else if (w <= s)
                raw = 64'd0;
            else
                raw = ((64'(dist_q) - s) * 64'd32768) / (w - s);
            wgt = (falpha_cfg > ALPHA_ONE) ? 64'd256 : 64'(falpha_cfg);
            acc = (wgt * raw + (64'd256 - wgt) * 64'(factor_q)) >> 8;
            if (acc > 64'(Q15_ONE))
                acc = 64'(Q15_ONE);
            factor_q = acc[FACTOR_W-1:0];
            return factor_q;
        end
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        begin
            r = '0;
            r.is_write = 1'b1;
            r.reg_idx = idx;
            r.reg_data = data;
            return r;
        end
    endfunction

    function automatic plan_row_t tick_row(input logic sr, input logic [RANGE_W-1:0] rng);
        plan_row_t r;
        begin
            r = '0;
            r.sr = sr;
            r.rng = rng;
            return r;
        end
    endfunction

    function automatic plan_row_t known_row(input logic sr, input logic [RANGE_W-1:0] rng,
                                            input logic [FACTOR_W-1:0] want);
        plan_row_t r;
        begin
            r = tick_row(sr, rng);
            r.has_want = 1'b1;
            r.want = want;
            return r;
        end
    endfunction

    // range near the ramp band most of the time, plus extremes and noise
    function automatic logic [RANGE_W-1:0] pick_range();
        int lo;
        int hi;
        int span;
        int v;
        int unsigned pick;
        begin
            lo = (stop_cfg < slow_cfg) ? int'(stop_cfg) : int'(slow_cfg);
            hi = (stop_cfg < slow_cfg) ? int'(slow_cfg) : int'(stop_cfg);
            span = hi - lo;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                v = 0;
            else if (pick < 14)
                v = 65535;
            else if (pick < 30)
                v = int'($urandom_range(0, 65535));
            else
            begin
                v = lo + int'($urandom_range(0, span))
                    + int'($urandom_range(0, span / 2 + 16)) - (span / 4 + 8);
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
            end
            return v[RANGE_W-1:0];
        end
    endfunction

    // weights: mostly in range, sometimes anywhere in the 9-bit field
    function automatic logic [ALPHA_W-1:0] pick_alpha();
        begin
            if ($urandom_range(0, 3) == 0)
                return ALPHA_W'($urandom_range(0, 511));
            return ALPHA_W'($urandom_range(1, 256));
        end
    endfunction

    // let every queued factor arrive, then let the block go quiet
    task automatic settle_block();
        begin
            sample_ch.valid <= 1'b0;
            while (pending_factors.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // one register transfer; valid stays high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= data;
            do @(posedge clk); while (!cfg_ch.ready);
            case (idx)
                REG_STOP_DISTANCE:  stop_cfg   = data;
                REG_SLOW_DISTANCE:  slow_cfg   = data;
                REG_DISTANCE_ALPHA: dalpha_cfg = data[ALPHA_W-1:0];
                REG_FACTOR_ALPHA:   falpha_cfg = data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic apply_settings(input logic [RANGE_W-1:0] stop_v,
                                  input logic [RANGE_W-1:0] slow_v,
                                  input logic [ALPHA_W-1:0] da_v,
                                  input logic [ALPHA_W-1:0] fa_v);
        begin
            settle_block();
            write_register(REG_STOP_DISTANCE, stop_v);
            write_register(REG_SLOW_DISTANCE, slow_v);
            write_register(REG_DISTANCE_ALPHA, CFG_DATA_W'(da_v));
            write_register(REG_FACTOR_ALPHA, CFG_DATA_W'(fa_v));
            cfg_ch.valid <= 1'b0;
            settings_applied++;
        end
    endtask

    // one tick transfer, optionally after a gap; valid stays high afterwards
    task automatic send_sample(input logic sr, input logic [RANGE_W-1:0] rng,
                               input logic has_want, input logic [FACTOR_W-1:0] want);
        logic [FACTOR_W-1:0] predicted;
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            sample_ch.valid        <= 1'b1;
            sample_ch.sample_ready <= sr;
            sample_ch.range_mm     <= rng;
            do @(posedge clk); while (!sample_ch.ready);
            predicted = predict_speed_factor(sr, rng);
            pending_factors.push_back(has_want ? want : predicted);
            samples_sent++;
        end
    endtask

    // result side ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
        result_ch.ready <= (stall_left == 0);
    end

    // compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_factors.size() == 0)
            begin
                $error("speed_factor transfer with nothing pending, actual %0d",
                       result_ch.speed_factor);
                fail_count++;
            end
            else
            begin
                if (result_ch.speed_factor !== pending_factors[0])
                begin
                    $error("speed_factor mismatch: expected %0d, actual %0d",
                           pending_factors[0], result_ch.speed_factor);
                    fail_count++;
                end
                void'(pending_factors.pop_front());
                factors_checked++;
            end
        end
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $error("timeout with %0d speed factors still pending", pending_factors.size());
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial
    begin
        bit cfg_open;
        int phase;
        logic [RANGE_W-1:0] stop_v;
        logic [RANGE_W-1:0] slow_v;
        logic [ALPHA_W-1:0] da_v;
        logic [ALPHA_W-1:0] fa_v;

        cfg_open = 1'b0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_ready = 1'b0;
        sample_ch.range_mm = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;

        plan = '{
            // tick without sample right after reset
            known_row(1'b0, 16'hFFFF, 16'd29440),
            tick_row(1'b1, 16'd1000),
            tick_row(1'b1, 16'd500),
            // unit weights: output follows the raw ramp
            cfg_row(REG_FACTOR_ALPHA, 16'd256),
            cfg_row(REG_DISTANCE_ALPHA, 16'd256),
            known_row(1'b1, 16'hFFFF, 16'd32768),
            known_row(1'b1, 16'd0, 16'd0),
            known_row(1'b1, 16'd0, 16'd0),
            tick_row(1'b1, 16'd800),
            known_row(1'b1, 16'd250, 16'd0),
            known_row(1'b0, 16'hFFFF, 16'd0),
            known_row(1'b1, 16'd525, 16'd16384),
            // equal thresholds
            cfg_row(REG_STOP_DISTANCE, 16'd1000),
            cfg_row(REG_SLOW_DISTANCE, 16'd1000),
            known_row(1'b1, 16'd1000, 16'd0),
            known_row(1'b1, 16'd1001, 16'd32768),
            known_row(1'b1, 16'd999, 16'd0),
            // stop above slow
            cfg_row(REG_STOP_DISTANCE, 16'hFFFF),
            cfg_row(REG_SLOW_DISTANCE, 16'd0),
            known_row(1'b1, 16'd1, 16'd32768),
            known_row(1'b1, 16'd0, 16'd0),
            // widest band, weights above one
            cfg_row(REG_STOP_DISTANCE, 16'd0),
            cfg_row(REG_SLOW_DISTANCE, 16'hFFFF),
            cfg_row(REG_DISTANCE_ALPHA, 16'd511),
            cfg_row(REG_FACTOR_ALPHA, 16'd511),
            known_row(1'b1, 16'hFFFF, 16'd32768),
            known_row(1'b1, 16'd0, 16'd0),
            // filtered distance decays to zero, then reseeds
            cfg_row(REG_DISTANCE_ALPHA, 16'd255),
            tick_row(1'b1, 16'd1),
            tick_row(1'b1, 16'd0),
            tick_row(1'b1, 16'd0),
            tick_row(1'b1, 16'd5),
            // zero weights freeze both filters
            cfg_row(REG_FACTOR_ALPHA, 16'd0),
            cfg_row(REG_DISTANCE_ALPHA, 16'd0),
            tick_row(1'b1, 16'd40000),
            tick_row(1'b0, 16'd0),
            cfg_row(REG_FACTOR_ALPHA, 16'd300),
            cfg_row(REG_DISTANCE_ALPHA, 16'd128),
            tick_row(1'b1, 16'd30000),
            tick_row(1'b1, 16'hFFFF)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (!cfg_open)
                begin
                    settle_block();
                    settings_applied++;
                end
                write_register(plan[i].reg_idx, plan[i].reg_data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_ch.valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_sample(plan[i].sr, plan[i].rng, plan[i].has_want, plan[i].want);
            end
        end
        if (cfg_open)
            cfg_ch.valid <= 1'b0;

        // random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    stop_v = STOP_RESET;
                    slow_v = SLOW_RESET;
                    da_v = DALPHA_RESET;
                    fa_v = FALPHA_RESET;
                end
                1:
                begin
                    stop_v = 16'd0;
                    slow_v = 16'hFFFF;
                    da_v = ALPHA_ONE;
                    fa_v = ALPHA_ONE;
                end
                2:
                begin
                    stop_v = 16'hFFFF;
                    slow_v = 16'd0;
                    da_v = 9'd511;
                    fa_v = 9'd511;
                end
                3:
                begin
                    stop_v = 16'($urandom);
                    slow_v = stop_v;
                    da_v = pick_alpha();
                    fa_v = pick_alpha();
                end
                default:
                begin
                    stop_v = 16'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        slow_v = (stop_v > 16'd62535) ? 16'hFFFF
                                 : stop_v + 16'($urandom_range(1, 3000));
                    else
                        slow_v = 16'($urandom);
                    da_v = pick_alpha();
                    fa_v = pick_alpha();
                end
            endcase
            apply_settings(stop_v, slow_v, da_v, fa_v);
            idle_on = (phase < RANDOM_PHASES - 2);
            repeat (TICKS_PER_PHASE)
                send_sample($urandom_range(0, 99) < 85, pick_range(), 1'b0, '0);
        end

        // wait for the tail
        settle_block();

        $display("run covered %0d tick transfers under %0d register settings",
                 samples_sent, settings_applied);
        $display("%0d speed factors compared, %0d failures", factors_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
